>>> hw/rtl/fixed_priority_fifo_rr_scheduler_core_defines.svh
// Assertion macros used by the scheduler checker file.
`ifndef FIXED_PRIORITY_FIFO_RR_SCHEDULER_CORE_DEFINES_SVH
`define FIXED_PRIORITY_FIFO_RR_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define FPRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define FPRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/fprs_pkg.sv
// Package with the sizes, word types and codes of the scheduler core.
`default_nettype none

package fprs_pkg;

  localparam int NUM_TASKS = 32;
  localparam int SLOT_BITS = $clog2(NUM_TASKS);
  localparam int RANK_BITS = SLOT_BITS;
  localparam int CNT_BITS  = SLOT_BITS + 1;
  localparam int TIME_BITS = 13;
  localparam int PRIO_BITS = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_RANK_RD,
    ST_RANK_GAP,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [SLOT_BITS-1:0] task_slot;
    logic [TIME_BITS-1:0] compute_units;
    logic [TIME_BITS-1:0] release_time;
    logic [PRIO_BITS-1:0] prio_value;
    logic                 policy_rr;
  } req_t;

  typedef struct packed {
    logic                 ran_valid;
    logic [SLOT_BITS-1:0] ran_slot;
    logic                 finished;
    logic                 all_done;
    logic [TIME_BITS-1:0] now_tick;
  } rsp_t;

  // One task table entry as it sits in the task memory.
  typedef struct packed {
    logic [TIME_BITS-1:0] remaining;
    logic [TIME_BITS-1:0] rel_time;
    logic [PRIO_BITS-1:0] prio;
    logic                 policy;
  } task_entry_t;

  // Candidate or current winner of the selection pass.
  typedef struct packed {
    logic                 vld;
    logic [SLOT_BITS-1:0] slot;
    logic [RANK_BITS-1:0] rank;
    task_entry_t          entry;
  } pick_t;

  // Slot whose memory read data is present this cycle.
  typedef struct packed {
    logic                 vld;
    logic [SLOT_BITS-1:0] idx;
    logic                 last;
  } sweep_t;

  // Rank correction still owed to the stored queue ranks.
  typedef struct packed {
    logic                 vld;
    logic [RANK_BITS-1:0] gap_rank;
    logic                 requeue;
    logic [SLOT_BITS-1:0] self_slot;
    logic [RANK_BITS-1:0] new_rank;
  } gap_fix_t;

endpackage

`default_nettype wire

>>> hw/rtl/fprs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module fprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fprs_sweep.sv
// Slot sweep counter: issues one memory address a cycle and tracks the returning slot.
`default_nettype none

module fprs_sweep import fprs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      rd_en,
  output logic      [SLOT_BITS-1:0] rd_addr,
  output sweep_t                    hit
);

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_TASKS - 1);

  logic                 on;
  logic [SLOT_BITS-1:0] idx;

  assign rd_en   = on;
  assign rd_addr = idx;

  always_ff @(posedge clk) begin
    // The read data that returns next cycle belongs to the slot issued now.
    hit.idx  <= idx;
    hit.last <= (idx == LAST_SLOT);
    if (rst) begin
      on      <= 1'b0;
      idx     <= '0;
      hit.vld <= 1'b0;
    end else begin
      hit.vld <= on;
      if (start) begin
        on  <= 1'b1;
        idx <= '0;
      end else if (on) begin
        if (idx == LAST_SLOT) begin
          on <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fprs_pick.sv
// Selection unit: keeps the best ready task seen so far in the current pass.
`default_nettype none

module fprs_pick import fprs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire pick_t cand,
  output pick_t      best
);

  logic take;

  // Lower priority value wins; on equal priority the earlier queue rank wins.
  assign take = cand.vld &&
                (!best.vld ||
                 (cand.entry.prio < best.entry.prio) ||
                 ((cand.entry.prio == best.entry.prio) && (cand.rank < best.rank)));

  always_ff @(posedge clk) begin
    if (rst) begin
      best.vld <= 1'b0;
    end else if (start) begin
      best.vld <= 1'b0;
    end else if (take) begin
      best <= cand;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fixed_priority_fifo_rr_scheduler_core.sv
// Top level of the fixed-priority FIFO / round-robin task scheduler core.
//
//   channel | signals                    | word  | direction
//   --------+----------------------------+-------+----------
//   request | req_valid, req_ready, req  | req_t | in
//   result  | rsp_valid, rsp_ready, rsp  | rsp_t | out
//
// A tick word runs a sweep of all 32 slots through the task and rank memories (one
// slot a cycle, registered read data), then updates the winner in ST_FINISH and
// posts the result in ST_EMIT. Clear, plain load and unknown words go straight to
// ST_EMIT. A load that hits a ready slot passes through ST_RANK_RD and ST_RANK_GAP,
// after a flush sweep in ST_FLUSH when an earlier rank correction must be swept out.
// Reset is synchronous on rst; it clears the live and ready bits, the ready count,
// time and the handshake state; the memories need no clearing pass.
// A stalled result waits in the output register; the next word is accepted as soon
// as the result has been posted there, and the posting waits only for a free register.
`default_nettype none

module fixed_priority_fifo_rr_scheduler_core import fprs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Control state.
  state_t               state, state_next;
  logic [NUM_TASKS-1:0] live, live_next;
  logic [NUM_TASKS-1:0] ready, ready_next;
  logic [CNT_BITS-1:0]  ready_count, ready_count_next;
  logic [TIME_BITS-1:0] cur_time, cur_time_next;
  gap_fix_t             pend, pend_next;
  logic                 rsp_valid_next;

  // Payload state.
  req_t held, held_next;
  rsp_t res, res_next;
  rsp_t rsp_next;

  // Memory ports.
  logic                 task_we, task_re;
  logic [SLOT_BITS-1:0] task_waddr;
  task_entry_t          task_wdata, task_rdata;
  logic                 rank_we, rank_re;
  logic [SLOT_BITS-1:0] rank_waddr, rank_raddr;
  logic [RANK_BITS-1:0] rank_wdata, rank_rdata;

  // Sweep and selection.
  logic                 sweep_start;
  logic                 sw_rd_en;
  logic [SLOT_BITS-1:0] sw_rd_addr;
  sweep_t               sw_hit;
  logic                 pick_start;
  pick_t                cand;
  pick_t                best;

  // Per-slot values of the scan.
  logic                 arrive;
  logic [RANK_BITS-1:0] scan_rank;
  logic [TIME_BITS-1:0] rem_new;

  // Apply the rank correction left by the last removal from the ready order.
  // Ranks behind the gap move up by one; a round-robin task that was requeued
  // takes its place at the tail.
  function automatic logic [RANK_BITS-1:0] fix_rank(
    input gap_fix_t             g,
    input logic [SLOT_BITS-1:0] slot,
    input logic [RANK_BITS-1:0] q
  );
    logic [RANK_BITS-1:0] r;
    r = q;
    if (g.vld) begin
      if (g.requeue && (slot == g.self_slot)) begin
        r = g.new_rank;
      end else if (q > g.gap_rank) begin
        r = q - 1'b1;
      end
    end
    return r;
  endfunction

  // Task table: computation left, release time, priority and policy per slot.
  fprs_ram #(
    .WIDTH ($bits(task_entry_t)),
    .DEPTH (NUM_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_wdata),
    .re    (task_re),
    .raddr (sw_rd_addr),
    .rdata (task_rdata)
  );

  // Queue rank of each ready slot. The stored values may lag by one pending
  // correction, which every read applies on the way out.
  fprs_ram #(
    .WIDTH (RANK_BITS),
    .DEPTH (NUM_TASKS)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .re    (rank_re),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  fprs_sweep u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (sweep_start),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .hit     (sw_hit)
  );

  fprs_pick u_pick (
    .clk   (clk),
    .rst   (rst),
    .start (pick_start),
    .cand  (cand),
    .best  (best)
  );

  assign req_ready  = (state == ST_IDLE);
  assign task_re    = sw_rd_en && (state == ST_SCAN);
  assign rank_re    = sw_rd_en || (state == ST_RANK_RD);
  assign rank_raddr = (state == ST_RANK_RD) ? held.task_slot : sw_rd_addr;

  // A waiting task arrives when it is live, not yet ready and its release has come.
  // An arrival takes the next rank at the tail of the ready order.
  assign arrive    = live[sw_hit.idx] && !ready[sw_hit.idx] &&
                     (task_rdata.rel_time <= cur_time);
  assign scan_rank = arrive ? ready_count[RANK_BITS-1:0]
                            : fix_rank(pend, sw_hit.idx, rank_rdata);
  assign rem_new   = best.entry.remaining - 1'b1;

  always_comb begin
    state_next       = state;
    live_next        = live;
    ready_next       = ready;
    ready_count_next = ready_count;
    cur_time_next    = cur_time;
    pend_next        = pend;
    held_next        = held;
    res_next         = res;
    rsp_valid_next   = rsp_valid;
    rsp_next         = rsp;

    task_we     = 1'b0;
    task_waddr  = held.task_slot;
    task_wdata  = best.entry;
    rank_we     = 1'b0;
    rank_waddr  = sw_hit.idx;
    rank_wdata  = scan_rank;
    sweep_start = 1'b0;
    pick_start  = 1'b0;
    cand        = '0;

    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          held_next          = req;
          res_next           = '0;
          res_next.now_tick  = cur_time;
          unique case (req.cmd)
            CMD_CLEAR: begin
              live_next         = '0;
              ready_next        = '0;
              ready_count_next  = '0;
              cur_time_next     = '0;
              pend_next.vld     = 1'b0;
              res_next.now_tick = '0;
              state_next        = ST_EMIT;
            end
            CMD_LOAD: begin
              task_we                  = 1'b1;
              task_waddr               = req.task_slot;
              task_wdata.remaining     = req.compute_units;
              task_wdata.rel_time      = req.release_time;
              task_wdata.prio          = req.prio_value;
              task_wdata.policy        = req.policy_rr;
              live_next[req.task_slot] = (req.compute_units != '0);
              // A reload of a ready slot takes it out of the ready order. Its rank
              // is read once any older correction has been swept into memory.
              if (ready[req.task_slot]) begin
                if (pend.vld) begin
                  sweep_start = 1'b1;
                  state_next  = ST_FLUSH;
                end else begin
                  state_next  = ST_RANK_RD;
                end
              end else begin
                state_next = ST_EMIT;
              end
            end
            CMD_TICK: begin
              sweep_start = 1'b1;
              pick_start  = 1'b1;
              state_next  = ST_SCAN;
            end
            default: begin
              state_next = ST_EMIT;
            end
          endcase
        end
      end

      ST_FLUSH: begin
        if (sw_hit.vld && ready[sw_hit.idx]) begin
          rank_we    = 1'b1;
          rank_wdata = fix_rank(pend, sw_hit.idx, rank_rdata);
        end
        if (sw_hit.vld && sw_hit.last) begin
          pend_next.vld = 1'b0;
          state_next    = ST_RANK_RD;
        end
      end

      ST_RANK_RD: begin
        state_next = ST_RANK_GAP;
      end

      ST_RANK_GAP: begin
        pend_next.vld             = 1'b1;
        pend_next.gap_rank        = rank_rdata;
        pend_next.requeue         = 1'b0;
        pend_next.self_slot       = held.task_slot;
        pend_next.new_rank        = '0;
        ready_next[held.task_slot] = 1'b0;
        ready_count_next          = ready_count - 1'b1;
        state_next                = ST_EMIT;
      end

      ST_SCAN: begin
        // Arrivals and selection share one pass; the rank of every ready or arriving slot
        // is written back corrected (an arrival takes the tail), so the pass also retires the pending fix.
        if (sw_hit.vld) begin
          cand.vld   = ready[sw_hit.idx] || arrive;
          cand.slot  = sw_hit.idx;
          cand.rank  = scan_rank;
          cand.entry = task_rdata;
          rank_we    = cand.vld;
          if (arrive) begin
            ready_next[sw_hit.idx] = 1'b1;
            ready_count_next       = ready_count + 1'b1;
          end
          if (sw_hit.last) begin
            state_next = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        res_next.ran_valid = best.vld;
        res_next.ran_slot  = best.vld ? best.slot : '0;
        res_next.finished  = 1'b0;
        res_next.all_done  = 1'b0;
        res_next.now_tick  = cur_time;
        cur_time_next      = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
        pend_next.vld      = 1'b0;
        if (best.vld) begin
          task_we              = 1'b1;
          task_waddr           = best.slot;
          task_wdata.remaining = rem_new;
          if (rem_new == '0) begin
            // The task is done: it leaves the table and the ready order.
            res_next.finished    = 1'b1;
            live_next[best.slot]  = 1'b0;
            ready_next[best.slot] = 1'b0;
            ready_count_next     = ready_count - 1'b1;
            pend_next.vld        = 1'b1;
            pend_next.gap_rank   = best.rank;
            pend_next.requeue    = 1'b0;
            pend_next.self_slot  = best.slot;
            pend_next.new_rank   = '0;
          end else if (best.entry.policy) begin
            // Round robin: the task moves to the tail; the count is unchanged.
            pend_next.vld       = 1'b1;
            pend_next.gap_rank  = best.rank;
            pend_next.requeue   = 1'b1;
            pend_next.self_slot = best.slot;
            pend_next.new_rank  = RANK_BITS'(ready_count - 1'b1);
          end
        end
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next    = 1'b1;
          rsp_next          = res;
          rsp_next.all_done = ~|live;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      live        <= '0;
      ready       <= '0;
      ready_count <= '0;
      cur_time    <= '0;
      pend        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      live        <= live_next;
      ready       <= ready_next;
      ready_count <= ready_count_next;
      cur_time    <= cur_time_next;
      pend        <= pend_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
    res  <= res_next;
    rsp  <= rsp_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/fprs_checker.sv
// Port-level checker for the scheduler core, bound to the top level.
`default_nettype none
`include "fixed_priority_fifo_rr_scheduler_core_defines.svh"

module fprs_checker import fprs_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp
);

  // A stalled result word stays posted and unchanged.
  `FPRS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result word changed while stalled")

  // Every accepted word drops ready in the cycle after its acceptance.
  `FPRS_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready stayed high after an accepted word")

  // An idle block stays idle until a word arrives.
  `FPRS_ASSERT_NXT(a_idle_holds, req_ready && !req_valid, req_ready, "ready dropped without an accepted word")

  // Only a task that ran can finish.
  `FPRS_ASSERT_IMP(a_finish_ran, rsp_valid && rsp.finished, rsp.ran_valid, "finished flag without a running task")

endmodule

bind fixed_priority_fifo_rr_scheduler_core fprs_checker u_fprs_checker (.*);

`default_nettype wire
